// ----- hdl/thc_pkg.sv -----
// Shared types, constants and helper functions for the tilt-compensated heading block.
// Depends on nothing; every other file in hdl/ imports it.
package thc_pkg;

  // Angle resolution inside the CORDIC units and the number of rotation steps.
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ROT_STEPS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  // Port and datapath widths.
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int CORD_W = 52;
  localparam int ANG_W  = ANGLE_BITS + 2;

  // Normalization brings the larger component up to at least 2^NORM_LIM.
  localparam int NORM_LIM    = 40;
  localparam int NORM_STAGES = 7;

  // Pipeline depths of the submodules.
  localparam int ISQ_STAGES = RAD_W / 2;
  localparam int FLD_STAGES = 3;
  localparam int CRD_STAGES = 1 + NORM_STAGES + ROT_STEPS;

  // Conversion from internal angle units to output units.
  localparam int OUT_SH_R  = (ANGLE_BITS > OUT_W) ? ANGLE_BITS - OUT_W : 0;
  localparam int OUT_SH_L  = (ANGLE_BITS < OUT_W) ? OUT_W - ANGLE_BITS : 0;
  localparam int OUT_ROUND = (OUT_SH_R > 0) ? (1 << (OUT_SH_R - 1)) : 0;
  localparam int QUARTER   = 1 << (OUT_W - 2);

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(1) << (ANGLE_BITS - 1);

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Sample fields that travel alongside the arithmetic.
  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] mx;
    logic signed [IN_W-1:0] my;
    logic signed [IN_W-1:0] mz;
    logic [RAD_W-1:0]       s;
    logic                   degen;
  } rec_t;

  // Flags that follow an item through the CORDIC units.
  typedef struct packed {
    logic degen;
    logic hzero;
  } flag_t;

  // Rotation angle of step i, rounded to the internal angle resolution.
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
    return ANG_W'(t >> (32 - ANGLE_BITS));
  endfunction

  // Signed angle to output units, saturated to a quarter turn.
  function automatic logic [OUT_W-1:0] half_out(input logic signed [ANG_W-1:0] z);
    logic signed [39:0] w;
    logic signed [39:0] o;
    w = 40'(z);
    o = ((w + 40'(OUT_ROUND)) >>> OUT_SH_R) <<< OUT_SH_L;
    if (o > 40'(QUARTER)) begin
      o = 40'(QUARTER);
    end else if (o < -40'(QUARTER)) begin
      o = -40'(QUARTER);
    end
    return o[OUT_W-1:0];
  endfunction

  // Angle modulo one turn to output units.
  function automatic logic [OUT_W-1:0] turn_out(input logic signed [ANG_W-1:0] z);
    logic [39:0] u;
    u = 40'(z[ANGLE_BITS-1:0]);
    u = ((u + 40'(OUT_ROUND)) >> OUT_SH_R) << OUT_SH_L;
    return u[OUT_W-1:0];
  endfunction

endpackage

// ----- hdl/thc_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on thc_pkg.
module thc_isqrt (
  input  logic                       clk,
  input  logic [thc_pkg::RAD_W-1:0]  rad,
  output logic [thc_pkg::ROOT_W-1:0] root
);
  import thc_pkg::*;

  logic [RAD_W-1:0] v_q   [ISQ_STAGES];
  logic [RAD_W-1:0] res_q [ISQ_STAGES];

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] v_in;
    logic [RAD_W-1:0] res_in;
    logic [RAD_W:0]   trial;

    if (k == 0) begin : g_first
      assign v_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    // Subtract the trial value when it fits and set this result bit.
    always_ff @(posedge clk) begin
      if ({1'b0, v_in} >= trial) begin
        v_q[k]   <= RAD_W'({1'b0, v_in} - trial);
        res_q[k] <= (res_in >> 1) + BIT;
      end else begin
        v_q[k]   <= v_in;
        res_q[k] <= res_in >> 1;
      end
    end
  end

  assign root = res_q[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

// ----- hdl/thc_field.sv -----
// Tilt compensation of the magnetic vector as exact integer products, three stages.
// Depends on thc_pkg.
module thc_field (
  input  logic                              clk,
  input  logic signed [thc_pkg::IN_W-1:0]   ax,
  input  logic signed [thc_pkg::IN_W-1:0]   ay,
  input  logic signed [thc_pkg::IN_W:0]     aaz,
  input  logic signed [thc_pkg::IN_W-1:0]   mx,
  input  logic signed [thc_pkg::IN_W-1:0]   my,
  input  logic signed [thc_pkg::IN_W-1:0]   mz,
  input  logic [thc_pkg::RAD_W-1:0]         s,
  input  logic [thc_pkg::ROOT_W-1:0]        r,
  input  logic [thc_pkg::ROOT_W-1:0]        n,
  output logic signed [thc_pkg::CORD_W-1:0] hx,
  output logic signed [thc_pkg::CORD_W-1:0] hy
);
  import thc_pkg::*;

  // First products.
  logic signed [48:0]       p1;
  logic signed [31:0]       q;
  logic signed [31:0]       t;
  logic signed [32:0]       u;
  logic signed [31:0]       w;
  logic signed [IN_W-1:0]   ay1;
  logic [ROOT_W-1:0]        r1;
  logic [ROOT_W-1:0]        n1;

  // Second products.
  logic signed [48:0]       p1_2;
  logic signed [48:0]       qr;
  logic signed [48:0]       tay;
  logic signed [49:0]       un;
  logic signed [48:0]       wr;

  // Stage one: each term's first multiplication.
  always_ff @(posedge clk) begin
    p1  <= 49'(mx) * 49'($signed({1'b0, s}));
    q   <= 32'(mz) * 32'(ax);
    t   <= 32'(mx) * 32'(ax);
    u   <= 33'(my) * 33'(aaz);
    w   <= 32'(mz) * 32'(ay);
    ay1 <= ay;
    r1  <= r;
    n1  <= n;
  end

  // Stage two: each term's second multiplication.
  always_ff @(posedge clk) begin
    p1_2 <= p1;
    qr   <= 49'(q) * 49'($signed({1'b0, r1}));
    tay  <= 49'(t) * 49'(ay1);
    un   <= 50'(u) * 50'($signed({1'b0, n1}));
    wr   <= 49'(w) * 49'($signed({1'b0, r1}));
  end

  // Stage three: sum the terms.
  always_ff @(posedge clk) begin
    hx <= CORD_W'(p1_2) - CORD_W'(qr);
    hy <= CORD_W'(un) - CORD_W'(tay) - CORD_W'(wr);
  end

endmodule

// ----- hdl/thc_cordic.sv -----
// Pipelined vectoring CORDIC: half-turn fold, normalization, then rotation stages.
// Depends on thc_pkg.
module thc_cordic (
  input  logic                              clk,
  input  logic signed [thc_pkg::CORD_W-1:0] x_in,
  input  logic signed [thc_pkg::CORD_W-1:0] y_in,
  output logic signed [thc_pkg::ANG_W-1:0]  angle
);
  import thc_pkg::*;

  localparam int LAST = CRD_STAGES - 1;

  logic signed [CORD_W-1:0] x_q [CRD_STAGES];
  logic signed [CORD_W-1:0] y_q [CRD_STAGES];
  logic signed [ANG_W-1:0]  z_q [CRD_STAGES];

  // Fold a vector in the left half plane by half a turn.
  always_ff @(posedge clk) begin
    if (x_in < 0) begin
      x_q[0] <= -x_in;
      y_q[0] <= -y_in;
      z_q[0] <= HALF_TURN;
    end else begin
      x_q[0] <= x_in;
      y_q[0] <= y_in;
      z_q[0] <= '0;
    end
  end

  // Normalization: binary shift search, then one final doubling.
  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    localparam int NS   = (g < NORM_STAGES - 1) ? (32 >> g) : 1;
    localparam int LIMB = (g < NORM_STAGES - 1) ? NORM_LIM - NS : NORM_LIM;
    logic [CORD_W-1:0] mag_x;
    logic [CORD_W-1:0] mag_y;
    logic              fits;

    assign mag_x = (x_q[g] < 0) ? CORD_W'(-x_q[g]) : CORD_W'(x_q[g]);
    assign mag_y = (y_q[g] < 0) ? CORD_W'(-y_q[g]) : CORD_W'(y_q[g]);
    assign fits  = (mag_x < (CORD_W'(1) << LIMB)) && (mag_y < (CORD_W'(1) << LIMB));

    always_ff @(posedge clk) begin
      if (fits) begin
        x_q[g+1] <= x_q[g] <<< NS;
        y_q[g+1] <= y_q[g] <<< NS;
      end else begin
        x_q[g+1] <= x_q[g];
        y_q[g+1] <= y_q[g];
      end
      z_q[g+1] <= z_q[g];
    end
  end

  // Rotation steps: drive y toward zero and accumulate the angle.
  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
    localparam int K = 1 + NORM_STAGES + i;
    localparam logic signed [ANG_W-1:0] STEP = atan_step(i);
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;

    assign dx = y_q[K-1] >>> i;
    assign dy = x_q[K-1] >>> i;

    always_ff @(posedge clk) begin
      if (y_q[K-1] >= 0) begin
        x_q[K] <= x_q[K-1] + dx;
        y_q[K] <= y_q[K-1] - dy;
        z_q[K] <= z_q[K-1] + STEP;
      end else begin
        x_q[K] <= x_q[K-1] - dx;
        y_q[K] <= y_q[K-1] + dy;
        z_q[K] <= z_q[K-1] - STEP;
      end
    end
  end

  assign angle = z_q[LAST];

endmodule

// ----- hdl/tilt_compensated_heading.sv -----
// Tilt-compensated compass heading: roll, pitch and heading from accelerometer and magnetometer.
// Each sample passes through the two 16-stage square roots, the 3-stage field products
// and the 24-stage CORDIC units before its result is registered and done rises.
// Throughput is one transaction per cycle; busy stays low and results cannot be held off.
// Synchronous active-high reset clears the valid pipeline and done; data registers keep junk.
// Depends on thc_pkg, thc_isqrt, thc_field and thc_cordic.
module tilt_compensated_heading (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [thc_pkg::IN_W-1:0]  acc_x,
  input  logic signed [thc_pkg::IN_W-1:0]  acc_y,
  input  logic signed [thc_pkg::IN_W-1:0]  acc_z,
  input  logic signed [thc_pkg::IN_W-1:0]  mag_x,
  input  logic signed [thc_pkg::IN_W-1:0]  mag_y,
  input  logic signed [thc_pkg::IN_W-1:0]  mag_z,
  output logic                             done,
  output logic signed [thc_pkg::OUT_W-1:0] roll,
  output logic signed [thc_pkg::OUT_W-1:0] pitch,
  output logic [thc_pkg::OUT_W-1:0]        heading,
  output logic                             degenerate
);
  import thc_pkg::*;

  localparam int LAT     = 2 + ISQ_STAGES + FLD_STAGES + CRD_STAGES;
  localparam int REC_LEN = ISQ_STAGES + FLD_STAGES + 1;
  localparam int REC_END = ISQ_STAGES + FLD_STAGES;

  logic [LAT-1:0] vld_q;

  rec_t                   in1;
  logic [RAD_W-2:0]       sq_x;
  logic [RAD_W-2:0]       sq_y;
  logic [RAD_W-2:0]       sq_z;
  logic signed [31:0]     prod_x;
  logic signed [31:0]     prod_y;
  logic signed [31:0]     prod_z;

  rec_t                   rec_q [REC_LEN];
  logic [RAD_W-1:0]       n_sum;
  logic [ROOT_W-1:0]      root_s;
  logic [ROOT_W-1:0]      root_n;
  logic [ROOT_W-1:0]      r_q [FLD_STAGES];
  logic signed [IN_W:0]   aaz_f;
  logic signed [IN_W:0]   aaz_c;

  logic signed [CORD_W-1:0] hx;
  logic signed [CORD_W-1:0] hy;
  logic signed [ANG_W-1:0]  z_roll;
  logic signed [ANG_W-1:0]  z_pitch;
  logic signed [ANG_W-1:0]  z_head;
  flag_t                    fl_q [CRD_STAGES];

  // The pipeline takes a transaction in every cycle.
  assign busy = 1'b0;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
      done  <= 1'b0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
      done  <= vld_q[LAT-1];
    end
  end

  // Stage one: squares of the acceleration and the degenerate test.
  always_comb begin
    prod_x = 32'(acc_x) * 32'(acc_x);
    prod_y = 32'(acc_y) * 32'(acc_y);
    prod_z = 32'(acc_z) * 32'(acc_z);
  end

  always_ff @(posedge clk) begin
    in1.ax    <= acc_x;
    in1.ay    <= acc_y;
    in1.az    <= acc_z;
    in1.mx    <= mag_x;
    in1.my    <= mag_y;
    in1.mz    <= mag_z;
    in1.s     <= '0;
    in1.degen <= ((acc_y == '0) && (acc_z == '0)) ||
                 ((mag_x == '0) && (mag_y == '0) && (mag_z == '0));
    sq_x      <= prod_x[RAD_W-2:0];
    sq_y      <= prod_y[RAD_W-2:0];
    sq_z      <= prod_z[RAD_W-2:0];
  end

  // Stage two: sums of squares, then the sample rides a delay line.
  always_ff @(posedge clk) begin
    rec_q[0] <= '{ax: in1.ax, ay: in1.ay, az: in1.az,
                  mx: in1.mx, my: in1.my, mz: in1.mz,
                  s: {1'b0, sq_y} + {1'b0, sq_z}, degen: in1.degen};
    n_sum    <= {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
    for (int k = 1; k < REC_LEN; k++) begin
      rec_q[k] <= rec_q[k-1];
    end
  end

  // Square roots of the horizontal and total acceleration magnitudes.
  thc_isqrt u_sqrt_s (
    .clk  (clk),
    .rad  (rec_q[0].s),
    .root (root_s)
  );

  thc_isqrt u_sqrt_n (
    .clk  (clk),
    .rad  (n_sum),
    .root (root_n)
  );

  assign aaz_f = (rec_q[ISQ_STAGES].az < 0) ? -(IN_W+1)'(rec_q[ISQ_STAGES].az)
                                            : (IN_W+1)'(rec_q[ISQ_STAGES].az);

  // Compensated field components.
  thc_field u_field (
    .clk (clk),
    .ax  (rec_q[ISQ_STAGES].ax),
    .ay  (rec_q[ISQ_STAGES].ay),
    .aaz (aaz_f),
    .mx  (rec_q[ISQ_STAGES].mx),
    .my  (rec_q[ISQ_STAGES].my),
    .mz  (rec_q[ISQ_STAGES].mz),
    .s   (rec_q[ISQ_STAGES].s),
    .r   (root_s),
    .n   (root_n),
    .hx  (hx),
    .hy  (hy)
  );

  // Keep the horizontal root aligned with the field products.
  always_ff @(posedge clk) begin
    r_q[0] <= root_s;
    for (int k = 1; k < FLD_STAGES; k++) begin
      r_q[k] <= r_q[k-1];
    end
  end

  assign aaz_c = (rec_q[REC_END].az < 0) ? -(IN_W+1)'(rec_q[REC_END].az)
                                         : (IN_W+1)'(rec_q[REC_END].az);

  // Three angle units run side by side.
  thc_cordic u_cordic_roll (
    .clk   (clk),
    .x_in  (CORD_W'(aaz_c)),
    .y_in  (CORD_W'(rec_q[REC_END].ay)),
    .angle (z_roll)
  );

  thc_cordic u_cordic_pitch (
    .clk   (clk),
    .x_in  (CORD_W'($signed({1'b0, r_q[FLD_STAGES-1]}))),
    .y_in  (-CORD_W'(rec_q[REC_END].ax)),
    .angle (z_pitch)
  );

  thc_cordic u_cordic_head (
    .clk   (clk),
    .x_in  (hx),
    .y_in  (hy),
    .angle (z_head)
  );

  // Flags follow the angle units.
  always_ff @(posedge clk) begin
    fl_q[0] <= '{degen: rec_q[REC_END].degen, hzero: (hx == '0) && (hy == '0)};
    for (int k = 1; k < CRD_STAGES; k++) begin
      fl_q[k] <= fl_q[k-1];
    end
  end

  // Output register: convert the angles and apply the special cases.
  always_ff @(posedge clk) begin
    degenerate <= fl_q[CRD_STAGES-1].degen;
    if (fl_q[CRD_STAGES-1].degen) begin
      roll    <= '0;
      pitch   <= '0;
      heading <= '0;
    end else begin
      roll    <= half_out(z_roll);
      pitch   <= half_out(z_pitch);
      heading <= fl_q[CRD_STAGES-1].hzero ? '0 : turn_out(z_head);
    end
  end

endmodule

// ----- test/tilt_compensated_heading_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the tilt-compensated heading block.
// Depends on thc_pkg and the tilt_compensated_heading RTL; needs no other files.
module tilt_compensated_heading_tb;
  import thc_pkg::*;

  // Expected outputs of one transaction.
  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic [15:0]        heading;
    logic               degenerate;
  } attitude_t;

  // Bit-accurate attitude predictor and queue of pending attitudes.
  class attitude_board;
    attitude_t pending[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    static function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint unsigned int_root(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    static function longint rot_angle(int i);
      longint unsigned t;
      int sh;
      sh = 32 - ANGLE_BITS;
      t = {32'd0, ATAN_TURN32[i]};
      return longint'((t + (64'd1 << (sh - 1))) >> sh);
    endfunction

    // Vectoring CORDIC angle of (x, y), 2^ANGLE_BITS units per turn.
    static function longint vector_angle(longint x, longint y);
      longint z, dx, dy, lim;
      lim = 64'sd1 << 40;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 64'sd1 << (ANGLE_BITS - 1);
      end
      for (int k = 0; k < 48; k++) begin
        if ((x == 0 && y == 0) || x >= lim || x <= -lim || y >= lim || y <= -lim) break;
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += rot_angle(i);
        end else begin
          x -= dx; y += dy; z -= rot_angle(i);
        end
      end
      return z;
    endfunction

    static function logic [15:0] to_half(longint z);
      int sh;
      longint o;
      sh = ANGLE_BITS - 16;
      if (sh > 0) o = fshift(z + (64'sd1 << (sh - 1)), sh);
      else o = z <<< (-sh);
      if (o > 16384) o = 16384;
      if (o < -16384) o = -16384;
      return o[15:0];
    endfunction

    static function logic [15:0] to_turn(longint z);
      int sh;
      longint unsigned u;
      sh = ANGLE_BITS - 16;
      u = longint'(z) & ((64'd1 << ANGLE_BITS) - 1);
      if (sh > 0) u = (u + (64'd1 << (sh - 1))) >> sh;
      else u = u << (-sh);
      return u[15:0];
    endfunction

    // Note one accepted transaction and queue its expected attitude.
    function void note_sample(logic signed [15:0] ax_i, ay_i, az_i, mx_i, my_i, mz_i);
      longint ax, ay, az, mx, my, mz, s, nn, r, n, aaz, hx, hy;
      attitude_t e;
      ax = ax_i; ay = ay_i; az = az_i; mx = mx_i; my = my_i; mz = mz_i;
      if ((ay == 0 && az == 0) || (mx == 0 && my == 0 && mz == 0)) begin
        e = '{16'sd0, 16'sd0, 16'd0, 1'b1};
      end else begin
        s = ay * ay + az * az;
        nn = ax * ax + s;
        r = longint'(int_root(s));
        n = longint'(int_root(nn));
        aaz = (az < 0) ? -az : az;
        hx = mx * s - mz * ax * r;
        hy = -mx * ax * ay + my * aaz * n - mz * ay * r;
        e.roll = to_half(vector_angle(aaz, ay));
        e.pitch = to_half(vector_angle(r, -ax));
        e.heading = (hx == 0 && hy == 0) ? 16'd0 : to_turn(vector_angle(hx, hy));
        e.degenerate = 1'b0;
      end
      pending.push_back(e);
    endfunction

    // Compare one strobed result with the oldest expected attitude.
    function void check_result(attitude_t got);
      attitude_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result roll=%0d pitch=%0d heading=%0d degenerate=%0b",
                 $time, got.roll, got.pitch, got.heading, got.degenerate);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.roll !== e.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, e.roll, got.roll);
        errors++;
      end
      if (got.pitch !== e.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, got.pitch);
        errors++;
      end
      if (got.heading !== e.heading) begin
        $display("%0t: heading expected %0d actual %0d", $time, e.heading, got.heading);
        errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.degenerate,
                 got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic signed [15:0] mag_x = '0, mag_y = '0, mag_z = '0;
  logic done;
  logic signed [15:0] roll, pitch;
  logic [15:0] heading;
  logic degenerate;

  attitude_board board = new();

  tilt_compensated_heading dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .done(done), .roll(roll), .pitch(pitch), .heading(heading), .degenerate(degenerate)
  );

  always #1 clk = ~clk;

  // Check every strobed result at the rising edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_result('{roll, pitch, heading, degenerate});
    end
  end

  // Send one transaction and hold it until accepted; the caller lowers start.
  task automatic send_sample(logic signed [15:0] ax, ay, az, mx, my, mz);
    acc_x <= ax; acc_y <= ay; acc_z <= az;
    mag_x <= mx; mag_y <= my; mag_z <= mz;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_sample(ax, ay, az, mx, my, mz);
    @(negedge clk);
  endtask

  // Random gap with start low: mostly none or short, now and then long.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Sends back to back when no gap; otherwise lowers start for the gap.
  task automatic push_sample(logic signed [15:0] ax, ay, az, mx, my, mz, bit burst);
    acc_x <= ax; acc_y <= ay; acc_z <= az;
    mag_x <= mx; mag_y <= my; mag_z <= mz;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_sample(ax, ay, az, mx, my, mz);
    @(negedge clk);
    if (!burst) begin
      idle_gap();
    end
  endtask

  function automatic logic signed [15:0] rand_field();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus: directed corners, then random samples, then drain.
  initial begin
    logic signed [15:0] f [6];
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Level, axis-aligned, extremes and both degenerate conditions.
    send_sample(16'sd0, 16'sd0, 16'sd1000, 16'sd500, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd500, 16'sd100);
    send_sample(16'sd0, 16'sd0, 16'sd1000, -16'sd500, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd500, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd1000, 16'sd500, -16'sd1, 16'sd0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_sample(16'sd1000, 16'sd0, 16'sd0, 16'sd10, 16'sd20, 16'sd30);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd20, 16'sd30);
    send_sample(16'sd0, 16'sd100, 16'sd100, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
    send_sample(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, -16'sd1);
    // Field parallel to gravity gives a zero-length compensated field.
    send_sample(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd700);
    send_sample(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sh7FFF, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd0, -16'sd1, 16'sd0, 16'sd1, 16'sd0);

    // Sender pauses until every expected attitude has arrived.
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);

    // Random samples, some in back-to-back bursts.
    for (int i = 0; i < 1900; i++) begin
      foreach (f[j]) f[j] = rand_field();
      if ($urandom_range(0, 19) == 0) begin
        f[1] = 16'sd0;
        f[2] = 16'sd0;
      end
      push_sample(f[0], f[1], f[2], f[3], f[4], f[5], $urandom_range(0, 3) != 0);
      if (i == 1000) begin
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
      end
    end
    start <= 1'b0;

    // Drain and allow for stray strobes.
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- tilt_compensated_heading.f -----
hdl/thc_pkg.sv
hdl/thc_isqrt.sv
hdl/thc_field.sv
hdl/thc_cordic.sv
hdl/tilt_compensated_heading.sv
test/tilt_compensated_heading_tb.sv
